FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks shared by the RTL; define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// prop must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// cond must never be seen at a clock edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

FILE: rtl/dxt1_pkg.sv
// ----------------------------------------------------------------------------
// dxt1_pkg
// Widths, stream layouts, types and color helpers for the sub-block decoder.
// ----------------------------------------------------------------------------
package dxt1_pkg;

    localparam int ENDPOINT_W = 16;
    localparam int SELECT_W   = 32;
    localparam int COORD_W    = 10;
    localparam int CHAN_W     = 8;
    localparam int SUM_W      = 10;   // 2*255 + 255 fits
    localparam int PIXELS     = 16;
    localparam int CNT_W      = 4;

    // slave tdata: endpoint_a, endpoint_b, selector_rows, origin_x, origin_y
    localparam int S_DATA_W = 88;
    // master tdata: pixel_x, pixel_y, red, green, blue, alpha
    localparam int M_DATA_W = 56;
    localparam int M_PAD_W  = M_DATA_W - 2 * COORD_W - 4 * CHAN_W;

    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'd255;
    localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'd0;

    typedef enum logic [1:0] {
        SEL_C0   = 2'd0,
        SEL_C1   = 2'd1,
        SEL_MIX2 = 2'd2,
        SEL_MIX3 = 2'd3
    } sel_code_t;

    typedef struct packed {
        logic [CHAN_W-1:0] alpha;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } rgba_t;

    // bit replication to 8 bits
    function automatic logic [CHAN_W-1:0] widen5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [CHAN_W-1:0] widen6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

    // floor(v/3) for v < 768 via reciprocal 683/2048
    function automatic logic [CHAN_W-1:0] div3(input logic [SUM_W-1:0] v);
        logic [2*SUM_W-1:0] prod;
        prod = {{SUM_W{1'b0}}, v} * 20'd683;
        return prod[18:11];
    endfunction

endpackage

FILE: rtl/dxt1_subblock_decode.sv
// ----------------------------------------------------------------------------
// dxt1_subblock_decode
// Expands one 4x4 DXT1-style compressed sub-block into sixteen RGBA8 pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream takes one compressed sub-block per transfer: two RGB565
//   endpoints, 32 selector bits (row 0 in the top byte) and the origin.
//   Master stream gives one pixel per transfer in row-major order with its
//   wrapped texture coordinates; tlast marks the sixteenth pixel.
//   Path: a block passes through the block register, then the output
//   register, before its first pixel is valid.
//   Throughput: one pixel per cycle while the output is not stalled. The block
//   register is the only holding slot and frees when its last pixel moves
//   into the output register, so the next block is taken in that same cycle
//   and pixels stream with no gap.
//   The palette is rebuilt per pixel from the held endpoints: one add, one
//   constant multiply for the divide by three and a select, between the
//   block register and the output register.
//   Stall: while m_axis_tready is low a valid pixel stays in the output register and
//   the walk over the block pauses; s_axis_tready stays low as long as a
//   block is waiting in the block register.
//   Reset: rst_n clears both valid flags and the pixel counter; no block is
//   held and no pixel is offered.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dxt1_subblock_decode
    import dxt1_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // slave side
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // endpoint_a[15:0], endpoint_b[31:16], selector_rows[63:32],
    // origin_x[73:64], origin_y[83:74], zero[87:84]
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    // master side
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // pixel_x[9:0], pixel_y[19:10], red[27:20], green[35:28],
    // blue[43:36], alpha[51:44], zero[55:52]
    output logic [M_DATA_W-1:0] m_axis_tdata,
    output logic                m_axis_tlast    // last_pixel
);

    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(PIXELS - 1);

    // block register
    logic                  blk_valid_reg, blk_valid_next;
    logic [CNT_W-1:0]      pix_cnt_reg, pix_cnt_next;
    logic [ENDPOINT_W-1:0] ea_reg, eb_reg;
    logic [SELECT_W-1:0]   sel_reg;       // shifted up two bits per pixel
    logic [COORD_W-1:0]    ox_reg, oy_reg;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0]   out_data_reg;
    logic                  out_last_reg;

    logic                  in_xfer;
    logic                  out_load;
    logic                  blk_done;
    rgba_t                 color;
    logic [COORD_W-1:0]    pix_x, pix_y;

    // output slot free or draining this cycle
    assign out_load      = blk_valid_reg && (!out_valid_reg || m_axis_tready);
    assign blk_done      = out_load && (pix_cnt_reg == LAST_CNT);
    assign s_axis_tready = !blk_valid_reg || blk_done;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    dxt1_palette u_palette (
        .endpoint_a (ea_reg),
        .endpoint_b (eb_reg),
        .sel        (sel_code_t'(sel_reg[SELECT_W-1 -: 2])),
        .color      (color)
    );

    // column offset in the low counter bits, row offset in the high ones
    assign pix_x = ox_reg + {{(COORD_W-2){1'b0}}, pix_cnt_reg[1:0]};
    assign pix_y = oy_reg + {{(COORD_W-2){1'b0}}, pix_cnt_reg[3:2]};

    always_comb
    begin
        blk_valid_next = blk_valid_reg;
        pix_cnt_next   = pix_cnt_reg;
        if (in_xfer)
        begin
            blk_valid_next = 1'b1;
            pix_cnt_next   = '0;
        end
        else if (out_load)
        begin
            blk_valid_next = !blk_done;
            pix_cnt_next   = pix_cnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_valid_reg <= 1'b0;
            pix_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            blk_valid_reg <= blk_valid_next;
            pix_cnt_reg   <= pix_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            ea_reg  <= s_axis_tdata[15:0];
            eb_reg  <= s_axis_tdata[31:16];
            sel_reg <= s_axis_tdata[63:32];
            ox_reg  <= s_axis_tdata[73:64];
            oy_reg  <= s_axis_tdata[83:74];
        end
        else if (out_load)
        begin
            sel_reg <= {sel_reg[SELECT_W-3:0], 2'b00};
        end

        if (out_load)
        begin
            out_data_reg <= {{M_PAD_W{1'b0}}, color.alpha, color.blue, color.green,
                             color.red, pix_y, pix_x};
            out_last_reg <= (pix_cnt_reg == LAST_CNT);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // a new block always starts its walk at pixel zero
    `ASSERT_CLK(a_blk_start, clk, rst_n,
        in_xfer |=> (blk_valid_reg && pix_cnt_reg == '0),
        "accepted block did not start at pixel zero")
    // a block is held until its sixteenth pixel has been issued
    `ASSERT_CLK(a_blk_hold, clk, rst_n,
        (out_load && !blk_done && !in_xfer) |=> blk_valid_reg,
        "block dropped before its last pixel")
    // the sixteenth pixel leaves with tlast, no other pixel does
    `ASSERT_CLK(a_last_mark, clk, rst_n,
        out_load |=> (m_axis_tvalid && (m_axis_tlast == ($past(pix_cnt_reg) == LAST_CNT))),
        "tlast does not match pixel position")

endmodule

FILE: rtl/dxt1_palette.sv
// ----------------------------------------------------------------------------
// dxt1_palette
// Resolves one 2-bit selector against the two RGB565 endpoints to RGBA8.
// ----------------------------------------------------------------------------
module dxt1_palette
    import dxt1_pkg::*;
(
    input  logic [ENDPOINT_W-1:0] endpoint_a,
    input  logic [ENDPOINT_W-1:0] endpoint_b,
    input  sel_code_t             sel,
    output rgba_t                 color
);

    logic              four_color;
    logic [CHAN_W-1:0] c0 [3];
    logic [CHAN_W-1:0] c1 [3];
    logic [CHAN_W-1:0] mix [3];

    assign four_color = endpoint_a > endpoint_b;

    assign c0[0] = widen5(endpoint_a[15:11]);
    assign c0[1] = widen6(endpoint_a[10:5]);
    assign c0[2] = widen5(endpoint_a[4:0]);
    assign c1[0] = widen5(endpoint_b[15:11]);
    assign c1[1] = widen6(endpoint_b[10:5]);
    assign c1[2] = widen5(endpoint_b[4:0]);

    // one blend per channel: 2:1 / 1:2 thirds, or the plain average
    always_comb
    begin
        logic [SUM_W-1:0] w0;
        logic [SUM_W-1:0] w1;
        logic [SUM_W-1:0] sum;
        for (int ch = 0; ch < 3; ch++)
        begin
            w0 = {2'b00, c0[ch]};
            w1 = {2'b00, c1[ch]};
            if (four_color)
            begin
                sum     = (sel == SEL_MIX2) ? ((w0 << 1) + w1) : (w0 + (w1 << 1));
                mix[ch] = div3(sum);
            end
            else
            begin
                sum     = w0 + w1;
                mix[ch] = sum[CHAN_W:1];
            end
        end
    end

    always_comb
    begin
        unique case (sel)
            SEL_C0:
            begin
                color = '{alpha: ALPHA_OPAQUE, blue: c0[2], green: c0[1], red: c0[0]};
            end
            SEL_C1:
            begin
                color = '{alpha: ALPHA_OPAQUE, blue: c1[2], green: c1[1], red: c1[0]};
            end
            SEL_MIX2:
            begin
                color = '{alpha: ALPHA_OPAQUE, blue: mix[2], green: mix[1], red: mix[0]};
            end
            SEL_MIX3:
            begin
                // transparent entry in three-color mode
                color = '{alpha: (four_color ? ALPHA_OPAQUE : ALPHA_CLEAR),
                          blue: mix[2], green: mix[1], red: mix[0]};
            end
            default:
            begin
                color = '0;
            end
        endcase
    end

endmodule
